// File: hw/rtl/evm_pv_pkg.sv
// ----------------------------------------------------------------------------
// evm_pv_pkg
// shared types, opcode constants and verdict codes of the push scan
// ----------------------------------------------------------------------------
package evm_pv_pkg;

    localparam int unsigned MAX_CODE_LEN = 32768;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned IDX_W        = 15;
    localparam int unsigned SKIP_W       = 6;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] OP_PUSH_LO   = 8'h60;
    localparam logic [7:0] OP_PUSH_HI   = 8'h7f;
    localparam logic [7:0] OP_PUSH_BASE = 8'h5f;
    localparam logic [7:0] MARK_A       = 8'ha2;
    localparam logic [7:0] MARK_B       = 8'h64;

    localparam logic [1:0] STATUS_SUCCESS    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;
    localparam logic [1:0] STATUS_RESERVED   = 2'd3;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_CODE_LEN);

    // one classified byte, as passed from front to back
    typedef struct packed {
        logic              first;
        logic              len_zero;
        logic [LEN_W-1:0]  len;
        logic              is_push;
        logic [SKIP_W-1:0] push_n;
        logic              is_mark_a;
        logic              is_mark_b;
    } t_fq_item;

endpackage

// File: hw/rtl/evm_pv_front.sv
// ----------------------------------------------------------------------------
// evm_pv_front
// input register stage: accepts bytes and classifies opcode and length
// ----------------------------------------------------------------------------
module evm_pv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_code_byte,
    input  logic [15:0]           i_code_length,
    input  logic                  i_first_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output evm_pv_pkg::t_fq_item  o_item
);

    logic                 r_valid;
    logic                 n_valid;
    evm_pv_pkg::t_fq_item r_item;
    evm_pv_pkg::t_fq_item n_item;
    logic                 take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_item.first     = i_first_byte;
        n_item.len_zero  = (i_code_length == 16'd0);
        // lengths above the cap are scanned as the cap
        n_item.len       = (i_code_length > evm_pv_pkg::LEN_CAP) ?
                           evm_pv_pkg::LEN_CAP : i_code_length;
        n_item.is_push   = (i_code_byte >= evm_pv_pkg::OP_PUSH_LO) &&
                           (i_code_byte <= evm_pv_pkg::OP_PUSH_HI);
        n_item.push_n    = evm_pv_pkg::SKIP_W'(i_code_byte - evm_pv_pkg::OP_PUSH_BASE);
        n_item.is_mark_a = (i_code_byte == evm_pv_pkg::MARK_A);
        n_item.is_mark_b = (i_code_byte == evm_pv_pkg::MARK_B);
    end

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/evm_pv_queue.sv
// ----------------------------------------------------------------------------
// evm_pv_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module evm_pv_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  evm_pv_pkg::t_fq_item               i_item,
    output logic                               o_valid,
    input  logic                               i_pop,
    output evm_pv_pkg::t_fq_item               o_item,
    output logic [evm_pv_pkg::QCNT_W-1:0]      o_count
);

    evm_pv_pkg::t_fq_item                  r_mem [evm_pv_pkg::QUEUE_DEPTH];
    logic [evm_pv_pkg::QPTR_W-1:0]         r_wr_ptr;
    logic [evm_pv_pkg::QPTR_W-1:0]         r_rd_ptr;
    logic [evm_pv_pkg::QCNT_W-1:0]         r_count;
    logic [evm_pv_pkg::QPTR_W-1:0]         n_wr_ptr;
    logic [evm_pv_pkg::QPTR_W-1:0]         n_rd_ptr;
    logic [evm_pv_pkg::QCNT_W-1:0]         n_count;
    logic                                  push;
    logic                                  pop;

    assign o_ready = (r_count != evm_pv_pkg::QCNT_W'(evm_pv_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == evm_pv_pkg::QPTR_W'(evm_pv_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == evm_pv_pkg::QPTR_W'(evm_pv_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: hw/rtl/evm_pv_back.sv
// ----------------------------------------------------------------------------
// evm_pv_back
// scan state update per byte and registered verdict output
// ----------------------------------------------------------------------------
module evm_pv_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_pop,
    input  evm_pv_pkg::t_fq_item               i_item,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic                               o_metadata_stop,
    output logic [evm_pv_pkg::IDX_W-1:0]       o_stop_index
);

    localparam int unsigned SUM_W = evm_pv_pkg::LEN_W + 1;

    logic [evm_pv_pkg::IDX_W-1:0]  r_idx;
    logic [evm_pv_pkg::SKIP_W-1:0] r_skip;
    logic                          r_armed;
    logic                          r_done;
    logic [evm_pv_pkg::IDX_W-1:0]  n_idx;
    logic [evm_pv_pkg::SKIP_W-1:0] n_skip;
    logic                          n_armed;
    logic                          n_done;

    logic [evm_pv_pkg::IDX_W-1:0]  idx_c;
    logic [evm_pv_pkg::SKIP_W-1:0] skip_c;
    logic                          armed_c;
    logic                          done_c;

    logic [SUM_W-1:0]              sum_push;
    logic [SUM_W-1:0]              sum_mark;
    logic [SUM_W-1:0]              sum_last;
    logic [SUM_W-1:0]              len_ext;

    logic                          emit;
    logic                          stop;
    logic                          chk;
    logic [1:0]                    res_status;
    logic                          res_meta;
    logic [evm_pv_pkg::IDX_W-1:0]  res_idx;

    logic                          r_out_valid;
    logic [1:0]                    r_status;
    logic                          r_meta;
    logic [evm_pv_pkg::IDX_W-1:0]  r_stop_idx;

    assign o_pop = i_valid && (!r_out_valid || i_ready);

    // a first byte starts from cleared state
    assign idx_c   = i_item.first ? '0   : r_idx;
    assign skip_c  = i_item.first ? '0   : r_skip;
    assign armed_c = i_item.first ? 1'b0 : r_armed;
    assign done_c  = i_item.first ? 1'b0 : r_done;

    assign len_ext  = SUM_W'(i_item.len);
    assign sum_push = SUM_W'(idx_c) + SUM_W'(i_item.push_n);
    assign sum_mark = SUM_W'(idx_c) + SUM_W'(6);
    assign sum_last = SUM_W'(idx_c) + SUM_W'(1);

    always_comb begin
        n_idx      = idx_c;
        n_skip     = skip_c;
        n_armed    = armed_c;
        n_done     = done_c;
        emit       = 1'b0;
        stop       = 1'b0;
        chk        = 1'b0;
        res_status = evm_pv_pkg::STATUS_SUCCESS;
        res_meta   = 1'b0;
        res_idx    = idx_c;
        if (!done_c) begin
            if (i_item.len_zero) begin
                emit       = 1'b1;
                res_status = evm_pv_pkg::STATUS_EMPTY;
                res_idx    = '0;
            end else begin
                n_idx = idx_c + 1'b1;
                if (armed_c) begin
                    n_armed = 1'b0;
                    if (i_item.is_mark_b) begin
                        emit     = 1'b1;
                        stop     = 1'b1;
                        res_meta = 1'b1;
                        res_idx  = idx_c - 1'b1;
                    end
                end
                if (!stop) begin
                    if (skip_c != '0) begin
                        n_skip = skip_c - 1'b1;
                        // last immediate byte is a check position
                        chk    = (skip_c == evm_pv_pkg::SKIP_W'(1));
                    end else if (i_item.is_push) begin
                        if (sum_push >= len_ext) begin
                            emit       = 1'b1;
                            stop       = 1'b1;
                            res_status = evm_pv_pkg::STATUS_INCOMPLETE;
                        end else begin
                            n_skip = i_item.push_n;
                        end
                    end else begin
                        chk = 1'b1;
                    end
                    if (!stop) begin
                        if (chk && i_item.is_mark_a && (sum_mark < len_ext)) begin
                            n_armed = 1'b1;
                        end
                        if (sum_last >= len_ext) begin
                            emit = 1'b1;
                        end
                    end
                end
            end
            if (emit) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_skip      <= '0;
            r_armed     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_idx   <= n_idx;
                r_skip  <= n_skip;
                r_armed <= n_armed;
                r_done  <= n_done;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_status   <= res_status;
            r_meta     <= res_meta;
            r_stop_idx <= res_idx;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_metadata_stop = r_meta;
    assign o_stop_index    = r_stop_idx;

endmodule

// File: hw/rtl/evm_bytecode_push_validator_top.sv
// path: a byte passes the input register, the queue and the verdict register before its
// verdict appears; the verdict waits in its register while the output is stalled
// throughput: one byte per cycle unless the output stalls, set by the back end's scan update
// reset: synchronous active-low i_rst_n clears scan state, queue and output valid
// ----------------------------------------------------------------------------
// evm_bytecode_push_validator_top
// push immediate scan of contract bytecode with metadata marker detection
// ----------------------------------------------------------------------------
module evm_bytecode_push_validator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // code_byte[7:0], code_length[23:8]
    input  logic        i_s_axis_tuser,  // first_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // status[1:0], metadata_stop[2], stop_index[17:3], zero
);

    logic                                  fr_valid;
    logic                                  q_ready;
    evm_pv_pkg::t_fq_item                  fr_item;
    logic                                  q_valid;
    logic                                  bk_pop;
    evm_pv_pkg::t_fq_item                  q_item;
    logic [evm_pv_pkg::QCNT_W-1:0]         q_count;
    logic [1:0]                            status;
    logic                                  metadata_stop;
    logic [evm_pv_pkg::IDX_W-1:0]          stop_index;

    evm_pv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_code_byte   (i_s_axis_tdata[7:0]),
        .i_code_length (i_s_axis_tdata[23:8]),
        .i_first_byte  (i_s_axis_tuser),
        .o_valid       (fr_valid),
        .i_ready       (q_ready),
        .o_item        (fr_item)
    );

    evm_pv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (q_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_pop   (bk_pop),
        .o_item  (q_item),
        .o_count (q_count)
    );

    evm_pv_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_pop           (bk_pop),
        .i_item          (q_item),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_status        (status),
        .o_metadata_stop (metadata_stop),
        .o_stop_index    (stop_index)
    );

    assign o_m_axis_tdata = {6'd0, stop_index, metadata_stop, status};

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= evm_pv_pkg::QCNT_W'(evm_pv_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (status != evm_pv_pkg::STATUS_RESERVED))
        else $error("reserved status code on output");

    a_meta_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && metadata_stop) |-> (status == evm_pv_pkg::STATUS_SUCCESS))
        else $error("metadata stop without success");

    a_empty_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (status == evm_pv_pkg::STATUS_EMPTY)) |->
        (stop_index == '0 && !metadata_stop))
        else $error("empty verdict with nonzero index");

endmodule
